// File: sv/modular_exponentiation_macros.svh
// Assertion helpers shared by the modular exponentiation RTL.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define MODEXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define MODEXP_ASSERT_IMP(lbl, ante, cons, msg) \
    `MODEXP_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define MODEXP_ASSERT_NXT(lbl, ante, cons, msg) \
    `MODEXP_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// File: sv/modexp_pkg.sv
package modexp_pkg;

    // Width of every operand and result field on the ports
    localparam int FIELD_W = 32;

    typedef struct packed {
        logic [FIELD_W-1:0] base_value;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } modexp_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] power_result;
        logic               zero_modulus_error;
    } modexp_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MULT,
        ST_FINISH
    } modexp_state_t;

endpackage

// File: sv/modexp_mulmod.sv
`include "modular_exponentiation_macros.svh"

// Bit-serial interleaved modular multiplier: product = a * b mod m.
// b is scanned MSB first, one bit per cycle; a and m must stay stable
// while the unit is busy. done pulses for one cycle with product valid.
module modexp_mulmod #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] product
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     bsh_reg, bsh_next;
    logic [W-1:0]     dbl;
    logic [W-1:0]     step;

    // (x + y) mod mm for x, y below mm; the sum never overflows W bits
    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x,
                                             input logic [W-1:0] y,
                                             input logic [W-1:0] mm);
        logic [W-1:0] gap;
        gap = mm - y;
        if (x >= gap)
            add_mod = x - gap;
        else
            add_mod = x + y;
    endfunction

    // One digit: double, then add a if the scanned bit is set
    always_comb
    begin
        dbl  = add_mod(acc_reg, acc_reg, m);
        step = bsh_reg[W-1] ? add_mod(dbl, a, m) : dbl;
    end

    // Sequencing of the scan
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        bsh_next  = bsh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            acc_next  = '0;
            bsh_next  = b;
        end
        else if (busy_reg)
        begin
            acc_next = step;
            bsh_next = {bsh_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        bsh_reg <= bsh_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

    `MODEXP_ASSERT_IMP(a_start_idle, start, !busy_reg, "multiplier restarted while busy")
    `MODEXP_ASSERT_IMP(a_cnt_live, busy_reg, cnt_reg != '0, "busy with an empty digit count")
    `MODEXP_ASSERT_NXT(a_acc_reduced, busy_reg && (m != '0), acc_reg < m,
                       "accumulator left the residue range")

endmodule

// File: sv/modular_exponentiation.sv
// A zero modulus or zero exponent goes straight to the finish state; otherwise the base is first
//   reduced mod the modulus, then each exponent bit up to the top set one takes a square and multiply step.
// One transaction at a time; the next is accepted once the result is posted. Bit-serial multipliers
//   (one scanned-operand bit per cycle, square and multiply side by side after the reduction) pace it.
// Reset: rst_n clears the controller and the output valid; no transaction is pending after reset.
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  modexp_pkg::modexp_in_t   req_data,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output modexp_pkg::modexp_out_t  rsp_data
);

    localparam int FW = modexp_pkg::FIELD_W;

    modexp_pkg::modexp_state_t state_reg, state_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    modexp_pkg::modexp_out_t   rsp_reg, rsp_next;
    logic [MOD_WIDTH-1:0]      m_reg, m_next;
    logic [MOD_WIDTH-1:0]      b_reg, b_next;
    logic [MOD_WIDTH-1:0]      r_reg, r_next;
    logic [EXP_WIDTH-1:0]      e_reg, e_next;
    logic                      err_reg, err_next;

    logic                      accept;
    logic                      out_free;
    logic [MOD_WIDTH-1:0]      base_in;
    logic [MOD_WIDTH-1:0]      mod_in;
    logic [EXP_WIDTH-1:0]      exp_in;
    logic [MOD_WIDTH-1:0]      scan0;
    logic                      start0, start1;
    logic                      done0, done1;
    logic [MOD_WIDTH-1:0]      prod0, prod1;

    // Operand truncation to the configured widths
    assign base_in  = MOD_WIDTH'(req_data.base_value);
    assign mod_in   = MOD_WIDTH'(req_data.modulus);
    assign exp_in   = EXP_WIDTH'(req_data.exponent);

    assign req_ready = (state_reg == modexp_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Unit 0 scans the raw base during reduction, the current base afterwards
    assign scan0 = (state_reg == modexp_pkg::ST_IDLE) ? base_in : b_reg;

    // Unit 0: reduction (1 * base) and the running product r * b
    modexp_mulmod #(.W(MOD_WIDTH)) u_mul_r (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start0),
        .a       (r_reg),
        .b       (scan0),
        .m       (m_reg),
        .done    (done0),
        .product (prod0)
    );

    // Unit 1: squaring b * b
    modexp_mulmod #(.W(MOD_WIDTH)) u_mul_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start1),
        .a       (b_reg),
        .b       (b_reg),
        .m       (m_reg),
        .done    (done1),
        .product (prod1)
    );

    // Controller: next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        m_next         = m_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        e_next         = e_reg;
        err_next       = err_reg;
        start0         = 1'b0;
        start1         = 1'b0;
        case (state_reg)
            modexp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    m_next   = mod_in;
                    e_next   = exp_in;
                    b_next   = base_in;
                    r_next   = MOD_WIDTH'(1);
                    err_next = (mod_in == '0);
                    if (mod_in == '0)
                    begin
                        r_next     = '0;
                        state_next = modexp_pkg::ST_FINISH;
                    end
                    else if (exp_in == '0)
                        state_next = modexp_pkg::ST_FINISH;
                    else
                    begin
                        start0     = 1'b1;
                        state_next = modexp_pkg::ST_REDUCE;
                    end
                end
            end
            modexp_pkg::ST_REDUCE:
            begin
                if (done0)
                begin
                    b_next     = prod0;
                    state_next = modexp_pkg::ST_STEP;
                end
            end
            modexp_pkg::ST_STEP:
            begin
                start0     = 1'b1;
                start1     = 1'b1;
                state_next = modexp_pkg::ST_MULT;
            end
            modexp_pkg::ST_MULT:
            begin
                if (done0)
                begin
                    if (e_reg[0])
                        r_next = prod0;
                    b_next = prod1;
                    e_next = e_reg >> 1;
                    if ((e_reg >> 1) == '0)
                        state_next = modexp_pkg::ST_FINISH;
                    else
                        state_next = modexp_pkg::ST_STEP;
                end
            end
            modexp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    rsp_valid_next               = 1'b1;
                    rsp_next.power_result        = FW'(r_reg);
                    rsp_next.zero_modulus_error  = err_reg;
                    state_next                   = modexp_pkg::ST_IDLE;
                end
            end
            default:
                state_next = modexp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= modexp_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        m_reg   <= m_next;
        b_reg   <= b_next;
        r_reg   <= r_next;
        e_reg   <= e_next;
        err_reg <= err_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    `MODEXP_ASSERT_IMP(a_err_zero, rsp_valid && rsp_data.zero_modulus_error,
                       rsp_data.power_result == '0, "error transaction with nonzero result")
    `MODEXP_ASSERT_IMP(a_units_lockstep, state_reg == modexp_pkg::ST_MULT, done0 == done1,
                       "square and multiply units out of step")
    `MODEXP_ASSERT_IMP(a_reduce_alone, state_reg == modexp_pkg::ST_REDUCE, !done1,
                       "squaring unit active during base reduction")
    `MODEXP_ASSERT_NXT(a_zero_mod_fast, accept && (mod_in == '0),
                       state_reg == modexp_pkg::ST_FINISH, "zero modulus not finished at once")

endmodule
